// File: rtl/core/hdrp_pkg.sv
// Shared types and constants for the IP/TCP/UDP header parser.
// No dependencies; imported by every module of the parser.
package hdrp_pkg;

    localparam logic [3:0] LINK_LOOPBACK = 4'd4;
    localparam logic [3:0] LINK_ETHERNET = 4'd14;
    localparam logic [5:0] IPV6_HDR      = 6'd40;
    localparam logic [5:0] IPV4_MIN_READ = 6'd20;
    localparam logic [5:0] UDP_HDR       = 6'd8;
    localparam logic [3:0] IP_VERSION_4  = 4'd4;
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] TCP_MIN_READ  = 8'd13;

    localparam logic [15:0] MATCH_PORT_RESET = 16'd1883;

    localparam logic [0:0] REG_LOOPBACK   = 1'd0;
    localparam logic [0:0] REG_MATCH_PORT = 1'd1;

    localparam logic [1:0] ST_MATCH     = 2'd0;
    localparam logic [1:0] ST_OTHER     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORT = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    typedef struct packed {
        logic [15:0] frame_len;
        logic [3:0]  link_bytes;
        logic [6:0]  transport_start;
        logic        is_ipv6;
        logic [7:0]  protocol;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [5:0]  transport_hdr_bytes;
    } hdrp_sum_t;

endpackage

// File: rtl/core/hdrp_front.sv
// Front end: follows the header layout byte by byte and builds a frame summary.
// Depends on hdrp_pkg.
module hdrp_front #(
    parameter int MAX_FRAME_BYTES = 16384
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               loopback_link,
    input  logic               accept,
    input  logic [7:0]         byte_value,
    input  logic               last_byte,
    output hdrp_pkg::hdrp_sum_t summary
);
    import hdrp_pkg::*;

    localparam logic [15:0] MAX_W = 16'(MAX_FRAME_BYTES);

    logic [15:0] pos_reg, pos_next;
    logic        ipv6_reg, ipv6_next;
    logic [5:0]  ihb_reg, ihb_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] sa_reg, sa_next;
    logic [31:0] da_reg, da_next;
    logic [15:0] sp_reg, sp_next;
    logic [15:0] dp_reg, dp_next;
    logic [5:0]  thb_reg, thb_next;

    logic [3:0]  link;
    logic [15:0] link16;
    logic [6:0]  t_w;
    logic [15:0] t16;
    logic        in_range;
    logic        after_link;

    always_comb
    begin
        link     = loopback_link ? LINK_LOOPBACK : LINK_ETHERNET;
        link16   = {12'd0, link};
        in_range = (pos_reg < MAX_W);

        ipv6_next  = ipv6_reg;
        ihb_next   = ihb_reg;
        proto_next = proto_reg;
        sa_next    = sa_reg;
        da_next    = da_reg;
        sp_next    = sp_reg;
        dp_next    = dp_reg;
        thb_next   = thb_reg;
        pos_next   = pos_reg;

        if (in_range && pos_reg == link16)
        begin
            if (byte_value[7:4] == IP_VERSION_4)
            begin
                ipv6_next = 1'b0;
                ihb_next  = {byte_value[3:0], 2'b00};
            end
            else
            begin
                ipv6_next = 1'b1;
                ihb_next  = IPV6_HDR;
            end
        end

        t_w        = {3'd0, link} + {1'b0, ihb_next};
        t16        = {9'd0, t_w};
        after_link = in_range && (pos_reg >= link16);

        if (after_link)
        begin
            if (ipv6_next)
            begin
                if (pos_reg == link16 + 16'd6)
                    proto_next = byte_value;
            end
            else
            begin
                if (pos_reg == link16 + 16'd9)
                    proto_next = byte_value;
                if (pos_reg >= link16 + 16'd12 && pos_reg < link16 + 16'd16)
                    sa_next = {sa_reg[23:0], byte_value};
                if (pos_reg >= link16 + 16'd16 && pos_reg < link16 + 16'd20)
                    da_next = {da_reg[23:0], byte_value};
            end
            if (pos_reg == t16 || pos_reg == t16 + 16'd1)
                sp_next = {sp_reg[7:0], byte_value};
            if (pos_reg == t16 + 16'd2 || pos_reg == t16 + 16'd3)
                dp_next = {dp_reg[7:0], byte_value};
            if (pos_reg == t16 + 16'd12)
                thb_next = {byte_value[7:4], 2'b00};
        end

        if (in_range)
            pos_next = pos_reg + 16'd1;

        summary.frame_len           = pos_next;
        summary.link_bytes          = link;
        summary.transport_start     = t_w;
        summary.is_ipv6             = ipv6_next;
        summary.protocol            = proto_next;
        summary.src_address         = ipv6_next ? 32'd0 : sa_next;
        summary.dst_address         = ipv6_next ? 32'd0 : da_next;
        summary.src_port            = sp_next;
        summary.dst_port            = dp_next;
        summary.transport_hdr_bytes = thb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            ipv6_reg  <= 1'b0;
            ihb_reg   <= '0;
            proto_reg <= '0;
            sa_reg    <= '0;
            da_reg    <= '0;
            sp_reg    <= '0;
            dp_reg    <= '0;
            thb_reg   <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg   <= '0;
                ipv6_reg  <= 1'b0;
                ihb_reg   <= '0;
                proto_reg <= '0;
                sa_reg    <= '0;
                da_reg    <= '0;
                sp_reg    <= '0;
                dp_reg    <= '0;
                thb_reg   <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                ipv6_reg  <= ipv6_next;
                ihb_reg   <= ihb_next;
                proto_reg <= proto_next;
                sa_reg    <= sa_next;
                da_reg    <= da_next;
                sp_reg    <= sp_next;
                dp_reg    <= dp_next;
                thb_reg   <= thb_next;
            end
        end
    end

endmodule

// File: rtl/core/hdrp_queue.sv
// Short queue of frame summaries between front end and back end.
// Depends on hdrp_pkg.
module hdrp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  hdrp_pkg::hdrp_sum_t wr_data,
    input  logic                rd_en,
    output hdrp_pkg::hdrp_sum_t rd_data,
    output logic                full,
    output logic                empty
);
    import hdrp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    hdrp_sum_t     entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: rtl/core/hdrp_back.sv
// Back end: classifies a frame summary and holds the result request.
// Depends on hdrp_pkg.
module hdrp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         match_port,
    input  hdrp_pkg::hdrp_sum_t sum,
    input  logic                sum_valid,
    output logic                sum_take,
    input  logic                pop,
    output logic                empty,
    output logic [1:0]          status,
    output logic                is_ipv6,
    output logic [31:0]         src_address,
    output logic [31:0]         dst_address,
    output logic [7:0]          protocol,
    output logic [15:0]         src_port,
    output logic [15:0]         dst_port,
    output logic [15:0]         payload_offset,
    output logic [15:0]         payload_length
);
    import hdrp_pkg::*;

    logic        valid_reg, valid_next;
    logic [1:0]  status_next;
    logic [15:0] sp_next, dp_next, poff_next, plen_next;
    logic [15:0] need_net;
    logic [5:0]  thl;
    logic [7:0]  t8, pay, need_tr;
    logic        is_tcp, is_udp;

    assign empty    = !valid_reg;
    assign sum_take = sum_valid && (!valid_reg || pop);

    always_comb
    begin
        is_tcp   = (sum.protocol == PROTO_TCP);
        is_udp   = (sum.protocol == PROTO_UDP);
        need_net = {12'd0, sum.link_bytes}
                 + {10'd0, (sum.is_ipv6 ? IPV6_HDR : IPV4_MIN_READ)};
        t8       = {1'b0, sum.transport_start};
        thl      = is_tcp ? sum.transport_hdr_bytes : UDP_HDR;
        pay      = t8 + {2'b00, thl};
        need_tr  = is_tcp ? (t8 + TCP_MIN_READ) : (t8 + {2'b00, UDP_HDR});
        if (pay > need_tr)
            need_tr = pay;

        status_next = ST_TRUNCATED;
        sp_next     = '0;
        dp_next     = '0;
        poff_next   = '0;
        plen_next   = '0;
        if (sum.frame_len < need_net)
            status_next = ST_TRUNCATED;
        else if (!is_tcp && !is_udp)
            status_next = ST_UNSUPPORT;
        else
        begin
            sp_next = sum.src_port;
            dp_next = sum.dst_port;
            if (sum.frame_len < {8'd0, need_tr})
                status_next = ST_TRUNCATED;
            else
            begin
                status_next = (sum.dst_port == match_port) ? ST_MATCH : ST_OTHER;
                poff_next   = {8'd0, pay};
                plen_next   = sum.frame_len - {8'd0, pay};
            end
        end

        valid_next = valid_reg;
        if (sum_take)
            valid_next = 1'b1;
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (sum_take)
        begin
            status         <= status_next;
            is_ipv6        <= sum.is_ipv6;
            src_address    <= sum.src_address;
            dst_address    <= sum.dst_address;
            protocol       <= sum.protocol;
            src_port       <= sp_next;
            dst_port       <= dp_next;
            payload_offset <= poff_next;
            payload_length <= plen_next;
        end
    end

endmodule

// File: rtl/core/ip_tcp_udp_header_parser_top.sv
// IP/TCP/UDP header parser: one frame byte per cycle while full is low,
// one result per frame, registered in the queue and then in the back end
// after the last byte is accepted. full rises only when the summary queue
// holds QUEUE_DEPTH frames that the result side has not taken. Reset:
// asynchronous, clears frame state, queue and pending result; loopback_link
// to 0, match_port to 1883. Depends on hdrp_pkg, hdrp_front/queue/back.
module ip_tcp_udp_header_parser_top #(
    parameter int MAX_FRAME_BYTES = 16384,
    parameter int QUEUE_DEPTH     = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic        is_ipv6,
    output logic [31:0] src_address,
    output logic [31:0] dst_address,
    output logic [7:0]  protocol,
    output logic [15:0] src_port,
    output logic [15:0] dst_port,
    output logic [15:0] payload_offset,
    output logic [15:0] payload_length
);
    import hdrp_pkg::*;

    logic        loopback_reg;
    logic [15:0] match_port_reg;
    logic        accept;
    logic        q_empty;
    logic        q_take;
    hdrp_sum_t   front_sum;
    hdrp_sum_t   q_sum;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loopback_reg   <= 1'b0;
            match_port_reg <= MATCH_PORT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LOOPBACK:   loopback_reg   <= cfg_data[0];
                REG_MATCH_PORT: match_port_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    hdrp_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .loopback_link(loopback_reg),
        .accept       (accept),
        .byte_value   (byte_value),
        .last_byte    (last_byte),
        .summary      (front_sum)
    );

    hdrp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept && last_byte),
        .wr_data(front_sum),
        .rd_en  (q_take),
        .rd_data(q_sum),
        .full   (full),
        .empty  (q_empty)
    );

    hdrp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .match_port    (match_port_reg),
        .sum           (q_sum),
        .sum_valid     (!q_empty),
        .sum_take      (q_take),
        .pop           (pop),
        .empty         (empty),
        .status        (status),
        .is_ipv6       (is_ipv6),
        .src_address   (src_address),
        .dst_address   (dst_address),
        .protocol      (protocol),
        .src_port      (src_port),
        .dst_port      (dst_port),
        .payload_offset(payload_offset),
        .payload_length(payload_length)
    );

endmodule

// File: rtl/core/hdrp_checker.sv
// Port-level checks for the header parser, attached by bind.
// Depends on hdrp_pkg and ip_tcp_udp_header_parser_top.
module hdrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write,
    input logic [0:0]  cfg_index,
    input logic [15:0] cfg_data,
    input logic        push,
    input logic        full,
    input logic [7:0]  byte_value,
    input logic        last_byte,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  status,
    input logic        is_ipv6,
    input logic [31:0] src_address,
    input logic [31:0] dst_address,
    input logic [7:0]  protocol,
    input logic [15:0] src_port,
    input logic [15:0] dst_port,
    input logic [15:0] payload_offset,
    input logic [15:0] payload_length
);
    import hdrp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(dst_port)
                              && $stable(payload_length)))
        else $error("pending request changed before pop");

    a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_TRUNCATED) |-> (payload_offset == 16'd0
                                                && payload_length == 16'd0))
        else $error("truncated request carries a payload");

    a_unsup: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_UNSUPPORT) |-> (src_port == 16'd0 && dst_port == 16'd0
                                                && payload_offset == 16'd0))
        else $error("unsupported transport carries ports");

    a_ipv6: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_ipv6) |-> (src_address == 32'd0 && dst_address == 32'd0))
        else $error("ipv6 request carries addresses");

endmodule

bind ip_tcp_udp_header_parser_top hdrp_checker u_hdrp_checker (.*);

// File: verif/hdrp_tb_pkg.sv
`timescale 1ns / 1ps
// Frame summary predictor and result scoreboard for the header parser bench.
// Depends on hdrp_pkg for the link, header, protocol, register and status codes.
package hdrp_tb_pkg;

    import hdrp_pkg::*;

    localparam int FRAME_LIMIT = 16384;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_ipv6;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [7:0]  protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
    } hdr_result_t;

    class frame_summary_board;
        logic        link_is_loopback;
        logic [15:0] match_port;

        logic [15:0] frame_pos;
        logic        ipv6_seen;
        logic [5:0]  net_hdr_len;
        logic [7:0]  proto_seen;
        logic [31:0] src_addr_seen;
        logic [31:0] dst_addr_seen;
        logic [15:0] src_port_seen;
        logic [15:0] dst_port_seen;
        logic [5:0]  tcp_hdr_len;

        hdr_result_t expected_summaries[$];
        int          mismatches;
        int          results_checked;
        int          status_count[4];

        function new();
            link_is_loopback = 1'b0;
            match_port       = MATCH_PORT_RESET;
            mismatches       = 0;
            results_checked  = 0;
            foreach (status_count[i])
                status_count[i] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            frame_pos     = '0;
            ipv6_seen     = 1'b0;
            net_hdr_len   = '0;
            proto_seen    = '0;
            src_addr_seen = '0;
            dst_addr_seen = '0;
            src_port_seen = '0;
            dst_port_seen = '0;
            tcp_hdr_len   = '0;
        endfunction

        function void write_config(logic [0:0] index, logic [15:0] value);
            if (index == REG_LOOPBACK)
                link_is_loopback = value[0];
            else
                match_port = value;
        endfunction

        function int link_len();
            return link_is_loopback ? int'(LINK_LOOPBACK) : int'(LINK_ETHERNET);
        endfunction

        function int pending();
            return expected_summaries.size();
        endfunction

        // Follow one accepted byte; on the last byte of a frame queue its summary.
        function void take_byte(logic [7:0] b, logic last);
            int          link;
            int          pos;
            int          t;
            int          len;
            int          need;
            int          hdr_len;
            hdr_result_t res;
            link = link_len();
            if (frame_pos < FRAME_LIMIT)
            begin
                pos = frame_pos;
                if (pos == link)
                begin
                    if (b[7:4] == IP_VERSION_4)
                    begin
                        ipv6_seen   = 1'b0;
                        net_hdr_len = {b[3:0], 2'b00};
                    end
                    else
                    begin
                        ipv6_seen   = 1'b1;
                        net_hdr_len = IPV6_HDR;
                    end
                end
                if (pos >= link)
                begin
                    if (ipv6_seen)
                    begin
                        if (pos == link + 6)
                            proto_seen = b;
                    end
                    else
                    begin
                        if (pos == link + 9)
                            proto_seen = b;
                        if (pos >= link + 12 && pos < link + 16)
                            src_addr_seen = {src_addr_seen[23:0], b};
                        if (pos >= link + 16 && pos < link + 20)
                            dst_addr_seen = {dst_addr_seen[23:0], b};
                    end
                    t = link + int'(net_hdr_len);
                    if (pos == t || pos == t + 1)
                        src_port_seen = {src_port_seen[7:0], b};
                    if (pos == t + 2 || pos == t + 3)
                        dst_port_seen = {dst_port_seen[7:0], b};
                    if (pos == t + 12)
                        tcp_hdr_len = {b[7:4], 2'b00};
                end
                frame_pos = frame_pos + 16'd1;
            end
            if (!last)
                return;

            res      = '0;
            len      = int'(frame_pos);
            t        = link + int'(net_hdr_len);
            res.is_ipv6  = ipv6_seen;
            res.protocol = proto_seen;
            if (!ipv6_seen)
            begin
                res.src_address = src_addr_seen;
                res.dst_address = dst_addr_seen;
            end
            need = link + (ipv6_seen ? int'(IPV6_HDR) : int'(IPV4_MIN_READ));
            if (len < need)
                res.status = ST_TRUNCATED;
            else if (proto_seen != PROTO_TCP && proto_seen != PROTO_UDP)
                res.status = ST_UNSUPPORT;
            else
            begin
                res.src_port = src_port_seen;
                res.dst_port = dst_port_seen;
                if (proto_seen == PROTO_TCP)
                begin
                    hdr_len = int'(tcp_hdr_len);
                    need    = t + int'(TCP_MIN_READ);
                end
                else
                begin
                    hdr_len = int'(UDP_HDR);
                    need    = t + int'(UDP_HDR);
                end
                if (t + hdr_len > need)
                    need = t + hdr_len;
                if (len < need)
                    res.status = ST_TRUNCATED;
                else
                begin
                    res.status         = (dst_port_seen == match_port) ? ST_MATCH : ST_OTHER;
                    res.payload_offset = 16'(t + hdr_len);
                    res.payload_length = 16'(len - (t + hdr_len));
                end
            end
            expected_summaries.push_back(res);
            clear_frame();
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_summary(hdr_result_t got);
            hdr_result_t want;
            if (expected_summaries.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_summaries.pop_front();
            results_checked++;
            status_count[want.status]++;
            compare_field("status", want.status, got.status);
            compare_field("is_ipv6", want.is_ipv6, got.is_ipv6);
            compare_field("src_address", want.src_address, got.src_address);
            compare_field("dst_address", want.dst_address, got.dst_address);
            compare_field("protocol", want.protocol, got.protocol);
            compare_field("src_port", want.src_port, got.src_port);
            compare_field("dst_port", want.dst_port, got.dst_port);
            compare_field("payload_offset", want.payload_offset, got.payload_offset);
            compare_field("payload_length", want.payload_length, got.payload_length);
        endfunction
    endclass

endpackage

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Top-level bench for ip_tcp_udp_header_parser_top: builds frames, streams them
// byte by byte with random gaps and stalls, and scores every summary.
// Depends on hdrp_pkg and hdrp_tb_pkg.
module testbench;

    import hdrp_pkg::*;
    import hdrp_tb_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int IDLE_CYCLES = 10;
    localparam int HOLD_CYCLES = 400;
    localparam int IP_VERSION_6 = 6;
    localparam int RANDOM_BYTES = 850;

    typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  byte_value = '0;
    logic        last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  status;
    logic        is_ipv6;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;

    frame_summary_board board;
    hdr_result_t        dut_summary;
    logic [7:0]         frame_buf[$];
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 bytes_sent = 0;
    int                 frames_sent = 0;
    int                 cycle_count = 0;
    logic               hold_results = 1'b0;
    event               hold_go;

    ip_tcp_udp_header_parser_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .byte_value     (byte_value),
        .last_byte      (last_byte),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .is_ipv6        (is_ipv6),
        .src_address    (src_address),
        .dst_address    (dst_address),
        .protocol       (protocol),
        .src_port       (src_port),
        .dst_port       (dst_port),
        .payload_offset (payload_offset),
        .payload_length (payload_length)
    );

    assign dut_summary = {status, is_ipv6, src_address, dst_address, protocol,
                          src_port, dst_port, payload_offset, payload_length};

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            board.check_summary(dut_summary);
        pop <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
    end

    // Hold the result side off long enough for the summary queue to fill.
    initial
    begin
        @(hold_go);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    task automatic offer_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        byte_value <= b;
        last_byte  <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.take_byte(b, last);
        bytes_sent++;
    endtask

    task automatic stream_frame();
        foreach (frame_buf[i])
            offer_byte(frame_buf[i], i == frame_buf.size() - 1);
        frames_sent++;
    endtask

    function automatic void build_frame(int ver, int ihl, logic [7:0] proto,
                                        logic [15:0] dport, int doff, int pay,
                                        int cut, fill_t fill);
        int link;
        int hdr;
        int t;
        int thl;
        int total;
        link  = board.link_len();
        hdr   = (ver == IP_VERSION_4) ? ihl * 4 : int'(IPV6_HDR);
        t     = link + hdr;
        thl   = (proto == PROTO_TCP) ? doff * 4 : int'(UDP_HDR);
        total = link + ((ver == IP_VERSION_4) ? int'(IPV4_MIN_READ) : int'(IPV6_HDR));
        if (t + thl > total)
            total = t + thl;
        if (proto == PROTO_TCP && t + int'(TCP_MIN_READ) > total)
            total = t + int'(TCP_MIN_READ);
        total += pay;
        frame_buf.delete();
        for (int i = 0; i < total; i++)
        begin
            case (fill)
                FILL_ZEROS: frame_buf.push_back(8'h00);
                FILL_ONES:  frame_buf.push_back(8'hFF);
                default:    frame_buf.push_back(8'($urandom));
            endcase
        end
        frame_buf[t + 2] = dport[15:8];
        frame_buf[t + 3] = dport[7:0];
        if (proto == PROTO_TCP)
            frame_buf[t + 12] = {4'(doff), frame_buf[t + 12][3:0]};
        if (ver == IP_VERSION_4)
        begin
            frame_buf[link]     = {IP_VERSION_4, 4'(ihl)};
            frame_buf[link + 9] = proto;
        end
        else
        begin
            frame_buf[link]     = {4'(ver), frame_buf[link][3:0]};
            frame_buf[link + 6] = proto;
        end
        if (cut > 0 && cut < total)
            frame_buf = frame_buf[0:cut - 1];
    endfunction

    task automatic send_frame(int ver, int ihl, logic [7:0] proto, logic [15:0] dport,
                              int doff, int pay, int cut, fill_t fill);
        build_frame(ver, ihl, proto, dport, doff, pay, cut, fill);
        stream_frame();
    endtask

    task automatic send_random_frame();
        int          kind;
        int          link;
        int          ver;
        int          ihl;
        int          doff;
        int          pay;
        int          cut;
        logic [7:0]  proto;
        logic [15:0] dport;
        link  = board.link_len();
        kind  = $urandom_range(99);
        ver   = ($urandom_range(3) == 0) ? IP_VERSION_6 : int'(IP_VERSION_4);
        if ($urandom_range(15) == 0)
            ver = $urandom_range(15);
        ihl   = ($urandom_range(4) == 0) ? $urandom_range(15) : 5;
        doff  = ($urandom_range(4) == 0) ? $urandom_range(15) : 5;
        proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
        dport = ($urandom_range(1) == 0) ? 16'($urandom) : board.match_port;
        pay   = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(6);
        cut   = -1;
        if (kind < 8)
            proto = 8'($urandom);
        else if (kind < 18)
            cut = $urandom_range(1, link + 60);
        if (kind >= 95)
        begin
            frame_buf.delete();
            repeat ($urandom_range(1, 70))
                frame_buf.push_back(8'($urandom));
            stream_frame();
        end
        else
            send_frame(ver, ihl, proto, dport, doff, pay, cut, FILL_RANDOM);
    endtask

    task automatic run_random(int min_frames);
        int n;
        int goal;
        n    = 0;
        goal = bytes_sent + RANDOM_BYTES / 4;
        while (n < min_frames || bytes_sent < goal)
        begin
            send_random_frame();
            n++;
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] index, logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        board.write_config(index, value);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
        @(posedge clk);
    endtask

    task automatic run_directed();
        int link;
        link = board.link_len();
        send_frame(IP_VERSION_4, 5, PROTO_UDP, MATCH_PORT_RESET, 0, 0, -1, FILL_RANDOM);
        send_frame(IP_VERSION_4, 5, PROTO_TCP, 16'd80, 5, 12, -1, FILL_RANDOM);
        send_frame(IP_VERSION_4, 15, PROTO_TCP, MATCH_PORT_RESET, 15, 3, -1, FILL_RANDOM);
        send_frame(IP_VERSION_4, 0, PROTO_TCP, 16'd1234, 0, 2, -1, FILL_RANDOM);
        send_frame(IP_VERSION_4, 1, PROTO_UDP, 16'd53, 0, 1, -1, FILL_RANDOM);
        send_frame(IP_VERSION_6, 0, PROTO_UDP, MATCH_PORT_RESET, 0, 5, -1, FILL_RANDOM);
        send_frame(IP_VERSION_6, 0, PROTO_TCP, 16'd443, 5, 4, -1, FILL_RANDOM);
        send_frame(0, 0, PROTO_TCP, 16'd22, 8, 0, -1, FILL_RANDOM);
        send_frame(15, 0, PROTO_UDP, 16'd7, 0, 0, -1, FILL_RANDOM);
        send_frame(IP_VERSION_4, 5, 8'd0, 16'd1, 0, 4, -1, FILL_RANDOM);
        send_frame(IP_VERSION_6, 0, 8'd255, 16'd1, 0, 0, -1, FILL_RANDOM);
        send_frame(IP_VERSION_4, 5, 8'd1, MATCH_PORT_RESET, 0, 0, -1, FILL_RANDOM);
        send_frame(IP_VERSION_4, 5, PROTO_UDP, 16'hFFFF, 0, 2, -1, FILL_ONES);
        send_frame(IP_VERSION_4, 5, PROTO_UDP, 16'h0000, 0, 2, -1, FILL_ZEROS);
        send_frame(15, 0, 8'hFF, 16'hFFFF, 0, 0, -1, FILL_ONES);
        send_frame(0, 0, 8'h00, 16'h0000, 0, 0, -1, FILL_ZEROS);
        send_frame(IP_VERSION_4, 5, PROTO_UDP, 16'd9, 0, 0, 1, FILL_ONES);
        send_frame(IP_VERSION_4, 5, PROTO_UDP, 16'd9, 0, 0, link + 19, FILL_RANDOM);
        send_frame(IP_VERSION_6, 0, PROTO_UDP, 16'd9, 0, 0, link + 39, FILL_RANDOM);
        send_frame(IP_VERSION_4, 5, PROTO_TCP, 16'd9, 3, 0, link + 32, FILL_RANDOM);
        send_frame(IP_VERSION_4, 5, PROTO_UDP, 16'd9, 0, 0, link + 27, FILL_RANDOM);
        send_frame(IP_VERSION_4, 5, PROTO_TCP, 16'd9, 15, 0, link + 79, FILL_RANDOM);
        // overlong frame: length saturates at the frame limit
        send_frame(IP_VERSION_4, 5, PROTO_UDP, MATCH_PORT_RESET, 0, FRAME_LIMIT + 16, -1,
                   FILL_RANDOM);
    endtask

    initial
    begin
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(17, 78);
        run_directed();
        settle();
        write_reg(REG_LOOPBACK, 16'd1);
        write_reg(REG_MATCH_PORT, 16'd0);
        run_random(16);
        settle();

        set_idling(78, 17);
        write_reg(REG_LOOPBACK, 16'd0);
        write_reg(REG_MATCH_PORT, 16'hFFFF);
        run_random(16);
        settle();

        set_idling(0, 0);
        write_reg(REG_LOOPBACK, 16'd1);
        write_reg(REG_MATCH_PORT, MATCH_PORT_RESET);
        -> hold_go;
        run_random(16);
        settle();

        write_reg(REG_LOOPBACK, 16'd0);
        write_reg(REG_MATCH_PORT, 16'($urandom));
        run_random(16);
        settle();

        $display("streamed %0d frames (%0d bytes) over both link types, %0d summaries checked",
                 frames_sent, bytes_sent, board.results_checked);
        $display("status mix: match %0d, other %0d, unsupported %0d, truncated %0d",
                 board.status_count[ST_MATCH], board.status_count[ST_OTHER],
                 board.status_count[ST_UNSUPPORT], board.status_count[ST_TRUNCATED]);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
